@@ sv/eas_pkg.sv @@
// Package for the eased animation sampler: fixed-point widths, register
// indexes, easing codes and the per-item side flags. No dependencies.
`default_nettype none

package eas_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int EW        = FRAC_BITS + 1;          // eased value, 0..ONE
  localparam int SQW       = 2 * (FRAC_BITS + 1);    // square of a 0..ONE operand
  localparam int PW        = 33 + FRAC_BITS + 2;     // delta times eased value

  localparam logic [2:0] REG_ACTIVE   = 3'd0;
  localparam logic [2:0] REG_START    = 3'd1;
  localparam logic [2:0] REG_DURATION = 3'd2;
  localparam logic [2:0] REG_FROM     = 3'd3;
  localparam logic [2:0] REG_TO       = 3'd4;
  localparam logic [2:0] REG_MODE     = 3'd5;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_IN     = 2'd1;
  localparam logic [1:0] MODE_OUT    = 2'd2;
  localparam logic [1:0] MODE_IN_OUT = 2'd3;

  typedef struct packed {
    logic is_from;   // sample is the start value
    logic is_to;     // sample is the end value
  } side_t;

endpackage

`default_nettype wire

@@ sv/eased_animation_sampler_top.sv @@
// Eased animation sampler: pipelined tick-to-value interpolation.
// Depends on eas_pkg (widths, register indexes, easing codes).
`default_nettype none

// Usage
//   Configuration: write cfg_data to register cfg_index while cfg_we is high.
//   Registers: 0 active, 1 start tick, 2 duration, 3 from, 4 to, 5 easing.
//   Indexes 6 and 7 are ignored. Write only while no request is in flight.
//   Input channel (in_valid/in_ready/now_tick): one request per tick value.
//   Output channel (out_valid/out_ready/sample_value): one sample per request,
//   in request order.
// Timing
//   From acceptance to out_valid a request passes one setup stage,
//   one restoring-division stage per fraction bit (16), a squaring stage,
//   an easing stage, a scaling multiply, a round-toward-zero shift and the
//   output register. Throughput is one request per cycle while the output
//   is not stalled; the division chain, one quotient bit per stage, sets the depth.
// Reset
//   rst clears all stage valid bits and sets every configuration register
//   to zero; stage data registers keep whatever they hold.
// Stall
//   When out_valid is high and out_ready is low, the whole pipeline holds
//   and in_ready drops; nothing is dropped or repeated.
module eased_animation_sampler_top
  import eas_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        now_tick,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      sample_value
);

  // Configuration registers
  logic               anim_active;
  logic [31:0]        anim_start;
  logic [31:0]        anim_length;
  logic signed [31:0] from_value;
  logic signed [31:0] to_value;
  logic [1:0]         easing_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      anim_active <= 1'b0;
      anim_start  <= '0;
      anim_length <= '0;
      from_value  <= '0;
      to_value    <= '0;
      easing_mode <= MODE_LINEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE:   anim_active <= cfg_data[0];
        REG_START:    anim_start  <= cfg_data;
        REG_DURATION: anim_length <= cfg_data;
        REG_FROM:     from_value  <= cfg_data;
        REG_TO:       to_value    <= cfg_data;
        REG_MODE:     easing_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Advance every stage together; hold all of them while the output waits.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Setup stage and division chain. Stage 0 of the chain is the setup result:
  // remainder starts at elapsed ticks, which is below the duration whenever
  // the quotient is used.
  logic                 dv   [0:FRAC_BITS];
  logic [31:0]          rem  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] quo  [0:FRAC_BITS];
  side_t                side [0:FRAC_BITS];

  logic [31:0] elapsed;
  side_t       side_next;
  assign elapsed           = now_tick - anim_start;
  assign side_next.is_from = !anim_active || (anim_length == '0) || (now_tick <= anim_start);
  assign side_next.is_to   = elapsed >= anim_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= elapsed;
      quo[0]  <= '0;
      side[0] <= side_next;
    end
  end

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_div
    logic [32:0] shl;
    logic        ge;
    logic [32:0] diff;
    assign shl  = {rem[g], 1'b0};
    assign ge   = shl >= {1'b0, anim_length};
    assign diff = shl - {1'b0, anim_length};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[g+1] <= 1'b0;
      end else if (adv) begin
        dv[g+1] <= dv[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[g+1]  <= ge ? diff[31:0] : shl[31:0];
        quo[g+1]  <= {quo[g][FRAC_BITS-2:0], ge};
        side[g+1] <= side[g];
      end
    end
  end

  // Square stage: pick t or its complement for the selected curve.
  logic [FRAC_BITS-1:0] t_div;
  logic [FRAC_BITS:0]   inv;
  logic [FRAC_BITS:0]   sq_op;
  assign t_div = quo[FRAC_BITS];
  assign inv   = EW'(ONE) - {1'b0, t_div};

  always_comb begin
    case (easing_mode)
      MODE_IN:     sq_op = {1'b0, t_div};
      MODE_IN_OUT: sq_op = t_div[FRAC_BITS-1] ? inv : {1'b0, t_div};
      default:     sq_op = inv;
    endcase
  end

  logic                 v_e1;
  logic [FRAC_BITS-1:0] t_e1;
  logic [SQW-1:0]       sq_e1;
  side_t                side_e1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_e1 <= 1'b0;
    end else if (adv) begin
      v_e1 <= dv[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_e1    <= t_div;
      sq_e1   <= sq_op * sq_op;
      side_e1 <= side[FRAC_BITS];
    end
  end

  // Easing stage
  logic [EW-1:0] e_next;
  always_comb begin
    case (easing_mode)
      MODE_IN:     e_next = sq_e1[2*FRAC_BITS:FRAC_BITS];
      MODE_OUT:    e_next = EW'(ONE) - sq_e1[2*FRAC_BITS:FRAC_BITS];
      MODE_IN_OUT: e_next = t_e1[FRAC_BITS-1] ? EW'(ONE) - sq_e1[2*FRAC_BITS-1:FRAC_BITS-1]
                                              : sq_e1[2*FRAC_BITS-1:FRAC_BITS-1];
      default:     e_next = {1'b0, t_e1};
    endcase
  end

  logic          v_e2;
  logic [EW-1:0] e_e2;
  side_t         side_e2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_e2 <= 1'b0;
    end else if (adv) begin
      v_e2 <= v_e1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_e2    <= e_next;
      side_e2 <= side_e1;
    end
  end

  // Scale stage: delta times eased value at full width.
  logic signed [32:0] delta;
  assign delta = $signed({to_value[31], to_value}) - $signed({from_value[31], from_value});

  logic                 v_m1;
  logic signed [PW-1:0] prod_m1;
  side_t                side_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m1 <= 1'b0;
    end else if (adv) begin
      v_m1 <= v_e2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_m1 <= PW'(delta) * PW'($signed({1'b0, e_e2}));
      side_m1 <= side_e2;
    end
  end

  // Shift stage: divide by ONE, rounding toward zero.
  logic signed [PW-1:0] biased;
  assign biased = prod_m1 + (prod_m1[PW-1] ? PW'(ONE - 1) : PW'(0));

  logic               v_m2;
  logic signed [32:0] scaled_m2;
  side_t              side_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m2 <= 1'b0;
    end else if (adv) begin
      v_m2 <= v_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scaled_m2 <= biased[FRAC_BITS+32:FRAC_BITS];
      side_m2   <= side_m1;
    end
  end

  // Output stage: add the start value, then apply the end cases.
  logic [32:0] sum;
  assign sum = {from_value[31], from_value} + scaled_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_m2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (side_m2.is_from) begin
        sample_value <= from_value;
      end else if (side_m2.is_to) begin
        sample_value <= to_value;
      end else begin
        sample_value <= sum[31:0];
      end
    end
  end

  // Checks
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while output stalled");

  a_ease_range: assert property (@(posedge clk) disable iff (rst)
    v_e2 |-> (e_e2 <= EW'(ONE)))
    else $error("eased progress above one");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v_m2))
    else $error("output valid without a request in the last stage");

endmodule

`default_nettype wire
